[hdl/vbrt_pkg.sv]
// shared types and constants for the valid byte range tracker
// no dependencies; every other file imports this package
package vbrt_pkg;

	localparam int MAX_RANGES  = 8;
	localparam int OFFSET_BITS = 24;
	localparam int LEN_W       = 24;
	localparam int TIME_W      = 48;
	localparam int CNT_W       = $clog2(MAX_RANGES + 1);
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 48;

	typedef logic [OFFSET_BITS-1:0] pos_t;
	typedef logic [CNT_W-1:0]       cnt_t;

	localparam cnt_t MAX_CNT = cnt_t'(MAX_RANGES);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FILE_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CACHED_TIME = 1'd1;

	typedef enum logic {
		OP_QUERY  = 1'b0,
		OP_INSERT = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		opcode_t           opcode;
		pos_t              offset;
		pos_t              byte_count;
		logic [TIME_W-1:0] server_modified_time;
	} req_word_t;

	typedef struct packed {
		logic    hit;
		status_t status;
		logic    table_was_cleared;
		cnt_t    ranges_in_use;
	} rsp_word_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] wdata;
	} cfg_word_t;

	// contents of one interval cell
	typedef struct packed {
		pos_t low;
		pos_t high;
		logic used;
	} cell_state_t;

	// broadcast control from the sequencer to every cell
	typedef struct packed {
		logic clear_all;
		logic rotate;
		cnt_t active_len;
		logic tail_keep;
		logic write_new;
		pos_t new_low;
		pos_t new_high;
		pos_t head_low;
		pos_t head_high;
	} cell_ctrl_t;

	// containment query, end held as last index plus one
	typedef struct packed {
		pos_t                 start;
		logic [OFFSET_BITS:0] end_p1;
	} query_t;

endpackage

[hdl/vbrt_if.sv]
// handshake channels of the valid byte range tracker: request, response, config
// depends on vbrt_pkg
interface vbrt_req_if import vbrt_pkg::*; ();
	logic      valid;
	logic      ready;
	req_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface vbrt_rsp_if import vbrt_pkg::*; ();
	logic      valid;
	logic      ready;
	rsp_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface vbrt_cfg_if import vbrt_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

[hdl/vbrt_cell.sv]
// one interval cell of the chain: holds low, high and used, shifts from its neighbor
// depends on vbrt_pkg
module vbrt_cell import vbrt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cnt_t        idx,
	input  cell_ctrl_t  ctrl,
	input  cell_state_t nxt,
	input  query_t      qry,
	output cell_state_t cur,
	output logic        hit
);

	logic        used_q;
	pos_t        low_q;
	pos_t        high_q;
	cnt_t        idx_p1;
	logic        shift_en;
	logic        tail_en;
	logic        write_en;

	// position of this cell within the active part of the chain
	assign idx_p1   = idx + cnt_t'(1);
	assign shift_en = ctrl.rotate && (idx_p1 < ctrl.active_len);
	assign tail_en  = ctrl.rotate && (idx_p1 == ctrl.active_len);
	assign write_en = ctrl.write_new && (idx == ctrl.active_len);

	// used flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (ctrl.clear_all) begin
			used_q <= 1'b0;
		end else if (shift_en) begin
			used_q <= nxt.used;
		end else if (tail_en) begin
			used_q <= ctrl.tail_keep;
		end else if (write_en) begin
			used_q <= 1'b1;
		end
	end

	// interval bounds
	always_ff @(posedge clk) begin
		if (shift_en) begin
			low_q  <= nxt.low;
			high_q <= nxt.high;
		end else if (tail_en) begin
			low_q  <= ctrl.head_low;
			high_q <= ctrl.head_high;
		end else if (write_en) begin
			low_q  <= ctrl.new_low;
			high_q <= ctrl.new_high;
		end
	end

	assign cur = {low_q, high_q, used_q};

	// containment test against this interval
	assign hit = used_q && (low_q <= qry.start)
		&& (({1'b0, high_q} + (OFFSET_BITS+1)'(1)) >= qry.end_p1);

endmodule

[hdl/valid_byte_range_tracker.sv]
// top level of the valid byte range tracker: request sequencer and chain of interval cells
// depends on vbrt_pkg, vbrt_if and vbrt_cell
//
// usage
//   req: one word per item (opcode, offset, byte_count, server_modified_time)
//   rsp: one word per item (hit, status, table_was_cleared, ranges_in_use)
//   cfg: register writes, always ready; index 0 file_length, 1 cached_modified_time
// the intervals live in a row of MAX_RANGES cells, used ones packed at the front
// a query compares all cells at once; its word appears in the cycle after acceptance
// an empty insert also answers in the cycle after acceptance
// an insert walks the stored intervals through the chain, one per cycle: each
// leaves the head and re-enters at the tail if kept, else the chain shortens;
// S_PLACE then places the merged interval unless the table is full, and the insert
// word is registered there; after a clear the walk is skipped and S_PLACE follows
// acceptance directly
// one item is in flight at a time; req.ready is low during an insert walk
// a stalled rsp holds its word; the next item is taken in the cycle the word leaves
// reset empties the table and sets both registers to zero
module valid_byte_range_tracker import vbrt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	vbrt_req_if.sink    req,
	vbrt_rsp_if.source  rsp,
	vbrt_cfg_if.sink    cfg
);

	localparam int CMP_W = ((OFFSET_BITS > LEN_W) ? OFFSET_BITS : LEN_W) + 2;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_SCAN  = 3'b010,
		S_PLACE = 3'b100
	} state_t;

	state_t            state_q;
	cnt_t              cnt_q;
	cnt_t              len_q;
	cnt_t              rem_q;
	logic [LEN_W-1:0]  file_len_q;
	logic [TIME_W-1:0] cached_time_q;
	pos_t              start_q;
	pos_t              end_q;
	pos_t              acc_low_q;
	pos_t              acc_high_q;
	logic              cleared_q;
	rsp_word_t         rsp_q;
	logic              rsp_valid_q;

	logic                 req_acc;
	logic                 rsp_load;
	logic                 is_query;
	logic                 is_empty;
	logic [OFFSET_BITS:0] sum;
	logic                 out_of_range;
	pos_t                 ins_end;
	logic                 stale;
	cnt_t                 start_len;
	logic                 full;
	cnt_t                 len_next;

	cell_ctrl_t           ctrl;
	query_t               qry;
	cell_state_t          cells [MAX_RANGES];
	logic [MAX_RANGES-1:0] hit_vec;
	logic [MAX_RANGES-1:0] used_vec;
	logic [MAX_RANGES-1:0] prefix_mask;

	cell_state_t head;
	logic        hold_s;
	logic        hold_e;
	logic        enclosed;
	logic        keep_h;

	// handshakes
	assign req_acc   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// request decode
	assign is_query     = (req.data.opcode == OP_QUERY);
	assign is_empty     = (req.data.byte_count == '0);
	assign sum          = {1'b0, req.data.offset} + {1'b0, req.data.byte_count};
	assign out_of_range = CMP_W'(sum) > (CMP_W'(file_len_q) + CMP_W'(1));
	assign ins_end      = sum[OFFSET_BITS] ? '1 : (sum[OFFSET_BITS-1:0] - pos_t'(1));
	assign stale        = cached_time_q < req.data.server_modified_time;
	assign start_len    = stale ? '0 : cnt_q;
	assign full         = (len_q == MAX_CNT);
	assign len_next     = full ? len_q : (len_q + cnt_t'(1));

	assign qry.start  = req.data.offset;
	assign qry.end_p1 = sum;

	// fate of the interval leaving the head of the chain
	assign head     = cells[0];
	assign hold_s   = (head.low <= start_q) && (head.high >= start_q);
	assign hold_e   = (head.low <= end_q) && (head.high >= end_q);
	assign enclosed = (head.low > start_q) && (head.high < end_q);
	assign keep_h   = !(hold_s || hold_e || enclosed);

	// broadcast control
	always_comb begin
		ctrl.clear_all  = req_acc && !is_query && !is_empty && stale;
		ctrl.rotate     = (state_q == S_SCAN);
		ctrl.active_len = len_q;
		ctrl.tail_keep  = keep_h;
		ctrl.write_new  = (state_q == S_PLACE) && !full;
		ctrl.new_low    = acc_low_q;
		ctrl.new_high   = acc_high_q;
		ctrl.head_low   = head.low;
		ctrl.head_high  = head.high;
	end

	// chain of interval cells
	for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
		cell_state_t nxt;
		if (i == MAX_RANGES - 1) begin : g_last
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = cells[i+1];
		end
		vbrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (cnt_t'(i)),
			.ctrl   (ctrl),
			.nxt    (nxt),
			.qry    (qry),
			.cur    (cells[i]),
			.hit    (hit_vec[i])
		);
		assign used_vec[i] = cells[i].used;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_len_q    <= '0;
			cached_time_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_FILE_LENGTH: file_len_q    <= cfg.wdata[LEN_W-1:0];
				REG_CACHED_TIME: cached_time_q <= cfg.wdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// response valid: set when a word is formed, cleared when it leaves
	assign rsp_load = (state_q == S_PLACE) || (req_acc && (is_query || is_empty));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			len_q       <= '0;
			rem_q       <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_acc && !is_query && !is_empty) begin
						len_q   <= start_len;
						rem_q   <= start_len;
						cnt_q   <= start_len;
						state_q <= (start_len == '0) ? S_PLACE : S_SCAN;
					end
				end
				S_SCAN: begin
					rem_q <= rem_q - cnt_t'(1);
					if (!keep_h) begin
						len_q <= len_q - cnt_t'(1);
					end
					if (rem_q == cnt_t'(1)) begin
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					cnt_q       <= len_next;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// insert bounds, merge accumulator and response word
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					start_q    <= req.data.offset;
					end_q      <= ins_end;
					acc_low_q  <= req.data.offset;
					acc_high_q <= ins_end;
					cleared_q  <= stale;
					rsp_q.hit               <= is_query && !out_of_range && (|hit_vec);
					rsp_q.status            <= (is_query && out_of_range) ? ST_RANGE : ST_OK;
					rsp_q.table_was_cleared <= 1'b0;
					rsp_q.ranges_in_use     <= cnt_q;
				end
			end
			S_SCAN: begin
				if (hold_s && (head.low < acc_low_q)) begin
					acc_low_q <= head.low;
				end
				if (hold_e && (head.high > acc_high_q)) begin
					acc_high_q <= head.high;
				end
			end
			S_PLACE: begin
				rsp_q.hit               <= 1'b0;
				rsp_q.status            <= full ? ST_FULL : ST_OK;
				rsp_q.table_was_cleared <= cleared_q;
				rsp_q.ranges_in_use     <= len_next;
			end
			default: ;
		endcase
	end

	// expected used pattern for a packed table
	always_comb begin
		for (int i = 0; i < MAX_RANGES; i++) begin
			prefix_mask[i] = (cnt_t'(i) < cnt_q);
		end
	end

	// the table stays packed to the front between items
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (used_vec == prefix_mask))
		else $error("used intervals not packed to the front");

	// no new word taken while an insert is in progress
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !req.ready)
		else $error("request taken during insert");

	// the walk never runs past the active part of the chain
	a_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> ((rem_q != '0) && (rem_q <= len_q)))
		else $error("insert walk out of bounds");

	// a dropped insert only happens with every cell kept
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PLACE && full) |=> (rsp_q.ranges_in_use == MAX_CNT && cnt_q == MAX_CNT))
		else $error("full status with free cells");

	// stored count never exceeds the chain
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_CNT)
		else $error("interval count overflow");

endmodule
